// ----- rtl/frg_pkg.sv -----
// Shared types and constants for the fraction reducer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package frg_pkg;

  localparam int WIDTH = 32;
  localparam int MAG_W = WIDTH - 1;
  localparam int K_W   = $clog2(MAG_W);
  localparam int CNT_W = $clog2(MAG_W + 1);

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_DEN = 2'd1,
    ST_MOST_NEG = 2'd2
  } frg_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_GCD,
    S_DIVN,
    S_DIVD,
    S_FINISH
  } frg_state_e;

  typedef struct packed {
    logic signed [WIDTH-1:0] numerator;
    logic signed [WIDTH-1:0] denominator;
  } frg_in_t;

  typedef struct packed {
    logic signed [WIDTH-1:0] reduced_numerator;
    logic [MAG_W-1:0]        reduced_denominator;
    logic                    whole_number;
    frg_status_e             status;
  } frg_out_t;

  // handshake between the sequencer and an iterative unit
  typedef struct packed {
    logic             start;
    logic [MAG_W-1:0] op_a;
    logic [MAG_W-1:0] op_b;
  } frg_req_t;

  typedef struct packed {
    logic             done;
    logic [MAG_W-1:0] value;
  } frg_rsp_t;

endpackage

// ----- rtl/frg_gcd.sv -----
// Binary GCD of two nonzero magnitudes, one shift or subtract step per cycle.
// Depends on frg_pkg.
`timescale 1ns / 1ps

module frg_gcd
  import frg_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  frg_req_t req_i,
  output frg_rsp_t rsp_o
);

  logic [MAG_W-1:0] a_q, a_d, b_q, b_d, g_q, g_d;
  logic [K_W-1:0]   k_q, k_d;
  logic             busy_q, busy_d, done_q, done_d;
  logic [MAG_W:0]   diff_ab;
  logic [MAG_W-1:0] diff_ba;
  logic             a_gt_b;

  assign diff_ab = {1'b0, a_q} - {1'b0, b_q};
  assign diff_ba = b_q - a_q;
  assign a_gt_b  = !diff_ab[MAG_W] && (a_q != b_q);

  always_comb begin
    a_d    = a_q;
    b_d    = b_q;
    k_d    = k_q;
    g_d    = g_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      a_d    = req_i.op_a;
      b_d    = req_i.op_b;
      k_d    = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (a_q == b_q) begin
        g_d    = a_q << k_q;
        busy_d = 1'b0;
        done_d = 1'b1;
      end else if (!a_q[0] && !b_q[0]) begin
        a_d = a_q >> 1;
        b_d = b_q >> 1;
        k_d = k_q + 1'b1;
      end else if (!a_q[0]) begin
        a_d = a_q >> 1;
      end else if (!b_q[0]) begin
        b_d = b_q >> 1;
      end else if (a_gt_b) begin
        a_d = diff_ab[MAG_W-1:0] >> 1;
      end else begin
        b_d = diff_ba >> 1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
    k_q <= k_d;
    g_q <= g_d;
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.value = g_q;

endmodule

// ----- rtl/frg_div.sv -----
// Restoring divider, one quotient bit per cycle; op_a / op_b, op_b nonzero.
// Depends on frg_pkg.
`timescale 1ns / 1ps

module frg_div
  import frg_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  frg_req_t req_i,
  output frg_rsp_t rsp_o
);

  logic [MAG_W-1:0] quot_q, quot_d, rem_q, rem_d, dvs_q, dvs_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d, done_q, done_d;
  logic [MAG_W:0]   trial;
  logic [MAG_W+1:0] diff;
  logic             ge;

  assign trial = {rem_q, quot_q[MAG_W-1]};
  assign diff  = {1'b0, trial} - {2'b00, dvs_q};
  assign ge    = !diff[MAG_W+1];

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      quot_d = req_i.op_a;
      dvs_d  = req_i.op_b;
      rem_d  = '0;
      cnt_d  = CNT_W'(MAG_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // remainder stays below the divisor, so it fits MAG_W bits
      rem_d  = ge ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
      quot_d = {quot_q[MAG_W-2:0], ge};
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.value = quot_q;

endmodule

// ----- rtl/fraction_reduce_gcd_top.sv -----
// Fraction reducer top: sequencer, special-case checks, sign handling, output register.
// Depends on frg_pkg, frg_gcd and frg_div.
//
//   channel | dir | handshake             | payload
//   in      | in  | in_valid_i/in_stall_o  | in_data_i  (frg_in_t)
//   out     | out | out_valid_o/out_stall_i| out_data_o (frg_out_t)
//
// Zero-denominator, most-negative and zero-numerator items go from idle straight to finish.
// Others take one binary GCD (a data dependent number of subtract/shift steps) plus two
// passes through the one restoring divider: numerator, then denominator, over the GCD.
// Stall is high from acceptance until the result is loaded into the output register;
// a result held by out_stall_i waits there while the next transaction is processed.
// Reset clears control state only.
`timescale 1ns / 1ps

module fraction_reduce_gcd_top
  import frg_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  frg_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output frg_out_t out_data_o
);

  localparam logic [WIDTH-1:0] SBIT = {1'b1, {(WIDTH-1){1'b0}}};

  frg_state_e       state_q, state_d;
  logic [MAG_W-1:0] nmag_q, nmag_d, dmag_q, dmag_d, g_q, g_d;
  logic             neg_q, neg_d;
  logic [WIDTH-1:0] res_num_q, res_num_d;
  logic [MAG_W-1:0] res_den_q, res_den_d;
  frg_status_e      res_st_q, res_st_d;
  frg_out_t         out_q, out_d;
  logic             out_valid_q, out_valid_d;
  frg_req_t         gcd_req, div_req;
  frg_rsp_t         gcd_rsp, div_rsp;
  logic             in_acc;
  logic [WIDTH-1:0] n_in, d_in, n_neg, d_neg, q_signed;

  assign in_acc = in_valid_i && (state_q == S_IDLE);
  assign n_in   = in_data_i.numerator;
  assign d_in   = in_data_i.denominator;
  assign n_neg  = -n_in;
  assign d_neg  = -d_in;
  assign q_signed = neg_q ? -{1'b0, div_rsp.value} : {1'b0, div_rsp.value};

  frg_gcd u_gcd (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (gcd_req),
    .rsp_o (gcd_rsp)
  );

  frg_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  always_comb begin
    state_d     = state_q;
    nmag_d      = nmag_q;
    dmag_d      = dmag_q;
    g_d         = g_q;
    neg_d       = neg_q;
    res_num_d   = res_num_q;
    res_den_d   = res_den_q;
    res_st_d    = res_st_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    gcd_req     = '{start: 1'b0, op_a: nmag_q, op_b: dmag_q};
    div_req     = '{start: 1'b0, op_a: nmag_q, op_b: gcd_rsp.value};

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          nmag_d    = n_in[WIDTH-1] ? n_neg[MAG_W-1:0] : n_in[MAG_W-1:0];
          dmag_d    = d_in[WIDTH-1] ? d_neg[MAG_W-1:0] : d_in[MAG_W-1:0];
          neg_d     = n_in[WIDTH-1] ^ d_in[WIDTH-1];
          res_num_d = '0;
          res_den_d = MAG_W'(1);
          res_st_d  = ST_OK;
          if (d_in == '0) begin
            res_st_d = ST_ZERO_DEN;
            state_d  = S_FINISH;
          end else if (n_in == SBIT || d_in == SBIT) begin
            res_st_d = ST_MOST_NEG;
            state_d  = S_FINISH;
          end else if (n_in == '0) begin
            state_d = S_FINISH;
          end else begin
            // GCD unit loads the fresh magnitudes at the accepting edge
            gcd_req.start = 1'b1;
            gcd_req.op_a  = nmag_d;
            gcd_req.op_b  = dmag_d;
            state_d       = S_GCD;
          end
        end
      end
      S_GCD: begin
        if (gcd_rsp.done) begin
          g_d           = gcd_rsp.value;
          div_req.start = 1'b1;
          state_d       = S_DIVN;
        end
      end
      S_DIVN: begin
        div_req.op_a = dmag_q;
        div_req.op_b = g_q;
        if (div_rsp.done) begin
          res_num_d     = q_signed;
          div_req.start = 1'b1;
          state_d       = S_DIVD;
        end
      end
      S_DIVD: begin
        if (div_rsp.done) begin
          res_den_d = div_rsp.value;
          state_d   = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d.reduced_numerator   = res_num_q;
          out_d.reduced_denominator = res_den_q;
          out_d.whole_number        = (res_den_q == MAG_W'(1));
          out_d.status              = res_st_q;
          out_valid_d               = 1'b1;
          state_d                   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    nmag_q    <= nmag_d;
    dmag_q    <= dmag_d;
    g_q       <= g_d;
    neg_q     <= neg_d;
    res_num_q <= res_num_d;
    res_den_q <= res_den_d;
    res_st_q  <= res_st_d;
    out_q     <= out_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- rtl/frg_checker.sv -----
// Port-level checks for the fraction reducer, bound onto the top level.
// Depends on frg_pkg and fraction_reduce_gcd_top.
`timescale 1ns / 1ps

module frg_checker
  import frg_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_o,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input frg_out_t out_data_o
);

  // one transaction at a time: busy right after acceptance
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after acceptance");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  a_whole_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.whole_number ==
                    (out_data_o.reduced_denominator == MAG_W'(1)))
    else $error("whole_number inconsistent with denominator");

  a_flagged_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != ST_OK |->
      out_data_o.reduced_numerator == '0 &&
      out_data_o.reduced_denominator == MAG_W'(1))
    else $error("flagged result is not 0/1");

  a_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.reduced_denominator != '0)
    else $error("zero denominator in result");

endmodule

bind fraction_reduce_gcd_top frg_checker u_frg_checker (.*);
